[rtl/slz_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the LZ image decoder.
package slz_pkg;

    localparam int HIST_DEPTH = 1024;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int LIT_DEPTH  = 256;
    localparam int LIT_AW     = $clog2(LIT_DEPTH);
    localparam int COUNT_W    = 28;
    localparam int SIZE_W     = 27;
    localparam int WORD_W     = 16;
    localparam int RWIDTH_W   = 11;
    localparam int RCOUNT_W   = 16;
    localparam int CFG_W      = 16;
    localparam int DIST_W     = 11;

    localparam logic [RWIDTH_W-1:0] RWIDTH_RESET = 11'd512;
    localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = 16'd256;

    // register indexes
    localparam logic CFG_ROW_WIDTH = 1'b0;
    localparam logic CFG_ROW_COUNT = 1'b1;

    // func codes
    localparam logic [1:0] FUNC_FLAG    = 2'd0;
    localparam logic [1:0] FUNC_LITERAL = 2'd1;
    localparam logic [1:0] FUNC_START   = 2'd2;

    // flag byte fields
    localparam logic [7:0] FLAG_KIND_MASK = 8'hF0;
    localparam logic [7:0] FLAG_COPY_HI   = 8'h80;
    localparam logic [7:0] FLAG_COPY_LO   = 8'h40;
    localparam logic [7:0] FLAG_SEL_MASK  = 8'h30;
    localparam logic [7:0] FLAG_CNT_MASK  = 8'h0F;
    localparam logic [7:0] LIT_REF_BIAS   = 8'd15;   // (flag - 16) + 1

    // output word source
    localparam logic [1:0] SRC_LIT_IN  = 2'd0;
    localparam logic [1:0] SRC_HIST    = 2'd1;
    localparam logic [1:0] SRC_LITHIST = 2'd2;

    typedef struct packed {
        logic capture;
        logic clear;
        logic set_pending;
        logic lit_write;
        logic start_copy;
        logic start_litref;
        logic emit;
        logic next_copy;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] flag;
        logic       pending_zero;
        logic       image_full;
        logic       copy_more;
        logic       out_free;
    } status_t;

endpackage

[rtl/slz_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module slz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/slz_ctrl.sv]
// Request sequencer: decodes each accepted request and steps the datapath word by word.
module slz_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  slz_pkg::status_t status,
    output slz_pkg::cmd_t   cmd
);
    import slz_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (status.func)
                    FUNC_START:
                    begin
                        cmd.clear = 1'b1;
                    end
                    FUNC_LITERAL:
                    begin
                        if (!status.pending_zero)
                        begin
                            cmd.lit_write = 1'b1;
                            state_next    = S_EMIT;
                        end
                    end
                    FUNC_FLAG:
                    begin
                        // flags are dropped while literals are owed or the image is full
                        if (status.pending_zero && !status.image_full)
                        begin
                            if ((status.flag & FLAG_KIND_MASK) == 8'd0)
                            begin
                                cmd.set_pending = 1'b1;
                            end
                            else if ((status.flag & FLAG_COPY_HI) != 8'd0 &&
                                     (status.flag & FLAG_COPY_LO) != 8'd0)
                            begin
                                cmd.start_copy = 1'b1;
                                state_next     = S_READ;
                            end
                            else
                            begin
                                cmd.start_litref = 1'b1;
                                state_next       = S_READ;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.copy_more)
                    begin
                        cmd.next_copy = 1'b1;
                        state_next    = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/slz_datapath.sv]
// Datapath: config registers, counters, history RAMs and the output register.
module slz_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  slz_pkg::cmd_t                   cmd,
    output slz_pkg::status_t                status,
    input  logic [1:0]                      func,
    input  logic [7:0]                      code_byte,
    input  logic [slz_pkg::WORD_W-1:0]      literal_word,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [slz_pkg::CFG_W-1:0]       cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [slz_pkg::WORD_W-1:0]      pixel_word,
    output logic                            last_of_run,
    output logic                            image_done
);
    import slz_pkg::*;

    logic [RWIDTH_W-1:0] rw_reg;
    logic [RCOUNT_W-1:0] rc_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [SIZE_W-1:0]   size_next;

    logic [1:0]          func_reg;
    logic [7:0]          flag_reg;
    logic [WORD_W-1:0]   lit_reg;

    logic [4:0]          pending_reg;
    logic [HIST_AW-1:0]  op_reg;
    logic [LIT_AW-1:0]   lp_reg;
    logic [LIT_AW:0]     lcount_reg;
    logic [COUNT_W-1:0]  be_reg;
    logic [COUNT_W-1:0]  be_next;
    logic [DIST_W-1:0]   dist_reg;
    logic [3:0]          remain_reg;
    logic [1:0]          src_reg;
    logic                zero_reg;
    logic [HIST_AW-1:0]  hraddr_reg;
    logic [LIT_AW-1:0]   lraddr_reg;

    logic                out_valid_reg;
    logic [WORD_W-1:0]   pixel_reg;
    logic                last_reg;
    logic                done_reg;

    logic [9:0]          row;
    logic [1:0]          sel;
    logic [DIST_W-1:0]   d_raw;
    logic [DIST_W-1:0]   d_flag;
    logic [DIST_W-1:0]   d_use;
    logic [HIST_AW-1:0]  op_base;
    logic [COUNT_W-1:0]  be_base;
    logic [LIT_AW-1:0]   d_lit;
    logic                setup_copy;

    logic [WORD_W-1:0]   hist_rdata;
    logic [WORD_W-1:0]   lit_rdata;
    logic [WORD_W-1:0]   word;
    logic                word_last;
    logic                out_free;

    // image size in bytes, row width forced even
    assign size_next = SIZE_W'({rw_reg[RWIDTH_W-1:1], 1'b0}) * SIZE_W'(rc_reg);
    assign be_next   = be_reg + COUNT_W'(2);

    // copy distance in words
    assign row = rw_reg[RWIDTH_W-1:1];
    assign sel = 2'((flag_reg & FLAG_SEL_MASK) >> 4);
    always_comb
    begin
        case (sel)
            2'd0:    d_raw = DIST_W'(1);
            2'd1:    d_raw = {1'b0, row};
            2'd2:    d_raw = {1'b0, row} + DIST_W'(1);
            default: d_raw = (row != 10'd0) ? ({1'b0, row} - DIST_W'(1)) : DIST_W'(0);
        endcase
    end
    assign d_flag = (d_raw == '0) ? DIST_W'(1) : d_raw;

    // next copy read follows the word being written this cycle
    assign setup_copy = cmd.start_copy || cmd.next_copy;
    assign d_use      = cmd.start_copy ? d_flag : dist_reg;
    assign op_base    = cmd.emit ? (op_reg + HIST_AW'(1)) : op_reg;
    assign be_base    = cmd.emit ? be_next : be_reg;

    assign d_lit = flag_reg - LIT_REF_BIAS;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (src_reg)
            SRC_LIT_IN:  word = lit_reg;
            SRC_HIST:    word = zero_reg ? '0 : hist_rdata;
            SRC_LITHIST: word = zero_reg ? '0 : lit_rdata;
            default:     word = '0;
        endcase
    end
    assign word_last = (src_reg != SRC_HIST) || (remain_reg == 4'd0);

    slz_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (cmd.emit),
        .waddr (op_reg),
        .wdata (word),
        .raddr (hraddr_reg),
        .rdata (hist_rdata)
    );

    slz_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LIT_DEPTH)
    ) u_lit_ram (
        .clk   (clk),
        .we    (cmd.lit_write),
        .waddr (lp_reg),
        .wdata (lit_reg),
        .raddr (lraddr_reg),
        .rdata (lit_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg        <= RWIDTH_RESET;
            rc_reg        <= RCOUNT_RESET;
            size_reg      <= SIZE_W'(RWIDTH_RESET) * SIZE_W'(RCOUNT_RESET);
            pending_reg   <= '0;
            op_reg        <= '0;
            lp_reg        <= '0;
            lcount_reg    <= '0;
            be_reg        <= '0;
            remain_reg    <= '0;
            src_reg       <= SRC_LIT_IN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROW_WIDTH)
                begin
                    rw_reg <= cfg_data[RWIDTH_W-1:0];
                end
                else
                begin
                    rc_reg <= cfg_data[RCOUNT_W-1:0];
                end
            end
            size_reg <= size_next;

            if (cmd.clear)
            begin
                pending_reg <= '0;
                op_reg      <= '0;
                lp_reg      <= '0;
                lcount_reg  <= '0;
                be_reg      <= '0;
            end
            if (cmd.set_pending)
            begin
                pending_reg <= {1'b0, flag_reg[3:0] & FLAG_CNT_MASK[3:0]} + 5'd1;
            end
            if (cmd.lit_write)
            begin
                pending_reg <= pending_reg - 5'd1;
                lp_reg      <= lp_reg + LIT_AW'(1);
                if (lcount_reg != (LIT_AW+1)'(LIT_DEPTH))
                begin
                    lcount_reg <= lcount_reg + (LIT_AW+1)'(1);
                end
                src_reg <= SRC_LIT_IN;
            end
            if (cmd.start_copy)
            begin
                remain_reg <= flag_reg[3:0] & FLAG_CNT_MASK[3:0];
                src_reg    <= SRC_HIST;
            end
            if (cmd.next_copy)
            begin
                remain_reg <= remain_reg - 4'd1;
            end
            if (cmd.start_litref)
            begin
                src_reg <= SRC_LITHIST;
            end
            if (cmd.emit)
            begin
                op_reg <= op_reg + HIST_AW'(1);
                be_reg <= be_next;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            flag_reg <= code_byte;
            lit_reg  <= literal_word;
        end
        if (cmd.start_copy)
        begin
            dist_reg <= d_flag;
        end
        if (setup_copy)
        begin
            hraddr_reg <= op_base - d_use[HIST_AW-1:0];
            // reads before the image start come back as zero
            zero_reg   <= {(COUNT_W-DIST_W-1)'(0), d_use} > be_base[COUNT_W-1:1];
        end
        if (cmd.start_litref)
        begin
            lraddr_reg <= lp_reg - d_lit;
            zero_reg   <= {1'b0, d_lit} > lcount_reg;
        end
        if (cmd.emit)
        begin
            pixel_reg <= word;
            last_reg  <= word_last;
            done_reg  <= be_next >= {1'b0, size_reg};
        end
    end

    assign status.func         = func_reg;
    assign status.flag         = flag_reg;
    assign status.pending_zero = (pending_reg == 5'd0);
    assign status.image_full   = (be_reg >= {1'b0, size_reg});
    assign status.copy_more    = (src_reg == SRC_HIST) && (remain_reg != 4'd0);
    assign status.out_free     = out_free;

    assign out_valid   = out_valid_reg;
    assign pixel_word  = pixel_reg;
    assign last_of_run = last_reg;
    assign image_done  = done_reg;

endmodule

[rtl/short_lz_image_decompressor.sv]
// Flag-byte driven LZ image decoder, 16-bit words: top level.
// One request at a time. Flag, start and dropped requests pass the IDLE and DECODE states; a literal
// also passes EMIT to its word; a literal reference passes READ then EMIT; a back copy of n words
// passes READ and EMIT for each word, each word being one read and one write of the output history RAM.
// Reset (async, active low) empties the pipeline, zeroes all counters and pointers and loads
// row width 512 bytes and 256 rows; no RAM clearing pass: unwritten entries read as zero
// through the emitted-word and literal fill counts.
module short_lz_image_decompressor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [7:0]                  code_byte,
    input  logic [slz_pkg::WORD_W-1:0]  literal_word,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [slz_pkg::WORD_W-1:0]  pixel_word,
    output logic                        last_of_run,
    output logic                        image_done,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [slz_pkg::CFG_W-1:0]   cfg_data
);
    import slz_pkg::*;

    cmd_t    cmd;
    status_t status;

    slz_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    slz_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .func         (func),
        .code_byte    (code_byte),
        .literal_word (literal_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_word   (pixel_word),
        .last_of_run  (last_of_run),
        .image_done   (image_done)
    );

endmodule
